// ===== src/ilst_pkg.sv =====
// ----------------------------------------------------------------------------
// ilst_pkg: shared types and codes for the indexed list store
// Operation and status codes, field widths and the command that the top
// level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ilst_pkg;

  // field widths of the item ports
  localparam int KIND_W   = 2;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // width used for position and count compares (covers capacity up to 65535)
  localparam int CMP_W = 16;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // command broadcast to the cell row
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CMP_W-1:0] pos;
  } ilst_cmd_t;

endpackage

// ===== src/ilst_cell.sv =====
// ----------------------------------------------------------------------------
// ilst_cell: one storage slot of the list
// Holds one entry, shifts from its left neighbor on insert and from its
// right neighbor on remove, and drives its entry on the read tap when
// addressed.
// ----------------------------------------------------------------------------
module ilst_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                      clk,
  input  ilst_pkg::ilst_cmd_t       cmd,
  input  logic [VALUE_WIDTH-1:0]    value_in,
  input  logic [VALUE_WIDTH-1:0]    left,
  input  logic [VALUE_WIDTH-1:0]    right,
  output logic [VALUE_WIDTH-1:0]    value,
  output logic [VALUE_WIDTH-1:0]    tap
);
  import ilst_pkg::*;

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic hit;
  logic above;

  // where this slot sits relative to the addressed position
  assign hit   = (cmd.pos == IDX);
  assign above = (IDX > cmd.pos);

  // entry storage with shift in either direction
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (hit) begin
        value <= value_in;
      end else if (above) begin
        value <= left;
      end
    end else if (cmd.rem) begin
      if (hit || above) begin
        value <= right;
      end
    end
  end

  // read tap, zero unless addressed
  assign tap = hit ? value : '0;

endmodule

// ===== src/indexed_list_store.sv =====
// Latency: a result appears in the cycle after its item is accepted.
// Throughput: one item per cycle while no result is stalled; insert, remove and
// read need no extra steps because every cell shifts in parallel with its neighbors.
// An item is stalled only while a finished result waits and is stalled.
// Reset clears the count and the result valid; cell contents are not
// cleared, and entries at or above the count are never read.
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list with insert, remove and read by position
// A row of CAPACITY cells holds the list in order; a command broadcast to
// the row shifts entries up or down and an or-tree collects the read tap.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [ilst_pkg::KIND_W-1:0]         kind,
  input  logic [ilst_pkg::POS_W-1:0]          position,
  input  logic signed [ilst_pkg::DATA_W-1:0]  data_in,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [ilst_pkg::DATA_W-1:0]  data_out,
  output logic [ilst_pkg::STATUS_W-1:0]       status,
  output logic [ilst_pkg::COUNT_W-1:0]        count
);
  import ilst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]       held;
  logic [CNT_W-1:0]       held_next;
  logic [CMP_W-1:0]       held_ext;
  logic [CMP_W-1:0]       pos_ext;
  logic                   accept;
  logic                   is_ins;
  logic                   is_rem;
  logic                   is_rd;
  logic                   in_range;
  logic                   ins_range_err;
  logic                   full;
  logic                   ins_ok;
  logic                   rem_ok;
  logic                   rd_ok;
  logic [STATUS_W-1:0]    status_next;
  logic [DATA_W-1:0]      dout_next;
  logic [VALUE_WIDTH-1:0] din_v;
  logic [VALUE_WIDTH-1:0] rd_word;
  logic [DATA_W-1:0]      rd_ext;
  ilst_cmd_t              cmd;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_tap [CAPACITY];

  // handshake: take an item unless a waiting result is stalled
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // operation decode and range checks
  assign held_ext      = CMP_W'(held);
  assign pos_ext       = CMP_W'(position);
  assign is_ins        = (kind == KIND_INSERT);
  assign is_rem        = (kind == KIND_REMOVE);
  assign is_rd         = (kind == KIND_READ);
  assign in_range      = (pos_ext < held_ext);
  assign ins_range_err = (pos_ext > held_ext);
  assign full          = (held_ext == CMP_W'(CAPACITY));
  assign ins_ok        = is_ins && !ins_range_err && !full;
  assign rem_ok        = is_rem && in_range;
  assign rd_ok         = is_rd && in_range;

  // status code
  always_comb begin
    if (is_ins) begin
      if (ins_range_err) begin
        status_next = ST_RANGE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else if (is_rem || is_rd) begin
      status_next = in_range ? ST_OK : ST_RANGE;
    end else begin
      status_next = ST_RANGE;
    end
  end

  // command to the cell row
  assign cmd.ins = accept && ins_ok;
  assign cmd.rem = accept && rem_ok;
  assign cmd.pos = pos_ext;

  // value width conversion in and out
  generate
    if (VALUE_WIDTH <= DATA_W) begin : g_narrow
      assign din_v = data_in[VALUE_WIDTH-1:0];
    end else begin : g_wide_in
      assign din_v = {{(VALUE_WIDTH-DATA_W){data_in[DATA_W-1]}}, data_in};
    end
    if (VALUE_WIDTH >= DATA_W) begin : g_out_cut
      assign rd_ext = rd_word[DATA_W-1:0];
    end else begin : g_out_ext
      assign rd_ext = {{(DATA_W-VALUE_WIDTH){rd_word[VALUE_WIDTH-1]}}, rd_word};
    end
  endgenerate

  // row of cells, each linked to its neighbors
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v;
      logic [VALUE_WIDTH-1:0] right_v;
      if (i == 0) begin : g_first
        assign left_v = din_v;
      end else begin : g_mid_l
        assign left_v = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[i+1];
      end
      ilst_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .INDEX       (i)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .value_in (din_v),
        .left     (left_v),
        .right    (right_v),
        .value    (cell_val[i]),
        .tap      (cell_tap[i])
      );
    end
  endgenerate

  // collect the addressed entry from the taps
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  assign dout_next = (rem_ok || rd_ok) ? rd_ext : '0;

  // next count
  always_comb begin
    held_next = held;
    if (cmd.ins) begin
      held_next = held + CNT_W'(1);
    end else if (cmd.rem) begin
      held_next = held - CNT_W'(1);
    end
  end

  // count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      held <= held_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= dout_next;
      status   <= status_next;
      count    <= COUNT_W'(held_next);
    end
  end

endmodule

// ===== src/ilst_checker.sv =====
// ----------------------------------------------------------------------------
// ilst_checker: port-level checks for the indexed list store
// Watches the item handshakes and the result fields, bound to the top level.
// ----------------------------------------------------------------------------
module ilst_checker #(
  parameter int CAPACITY = 256
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic signed [ilst_pkg::DATA_W-1:0]  data_out,
  input logic [ilst_pkg::STATUS_W-1:0]       status,
  input logic [ilst_pkg::COUNT_W-1:0]        count
);
  import ilst_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(data_out) && $stable(status)
      && $stable(count))
    else $error("stalled result changed");

  // items are held back only behind a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("item stalled without a stalled result");

  // a rejected item returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> data_out == '0)
    else $error("rejected item returned data");

  // full status only with the store at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> count == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

  // an accepted item yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted item gave no result");

endmodule

bind indexed_list_store ilst_checker #(.CAPACITY(CAPACITY)) u_ilst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .data_out  (data_out),
  .status    (status),
  .count     (count)
);

// ===== tb/sv/indexed_list_store_checker.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_checker: list predictor and result scoreboard
// Watches both channels of the indexed list store, keeps its own copy of the
// ordered list, queues the expected result of every accepted item and
// compares each accepted result with the oldest one, field by field.
// ----------------------------------------------------------------------------
module indexed_list_store_checker #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic [ilst_pkg::KIND_W-1:0]         kind,
  input  logic [ilst_pkg::POS_W-1:0]          position,
  input  logic signed [ilst_pkg::DATA_W-1:0]  data_in,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  logic signed [ilst_pkg::DATA_W-1:0]  data_out,
  input  logic [ilst_pkg::STATUS_W-1:0]       status,
  input  logic [ilst_pkg::COUNT_W-1:0]        count,
  output int                                  fail_count,
  output int                                  pending
);
  import ilst_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } list_result_t;

  // predicted list contents and length
  logic signed [DATA_W-1:0] list_values [CAPACITY];
  int                       list_len;
  list_result_t             pending_results [$];
  int                       mismatches;

  initial begin
    list_len   = 0;
    mismatches = 0;
  end

  // apply one operation to the predicted list and queue its result
  task automatic apply_list_op(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] value);
    list_result_t res;
    int           p;
    int           i;
    p            = int'(pos);
    res.data_out = '0;
    res.status   = ST_OK;
    case (op)
      KIND_INSERT: begin
        if (p > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_values[i] = list_values[i-1];
          list_values[p] = value;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.data_out = list_values[p];
          for (i = p; i + 1 < list_len; i++) list_values[i] = list_values[i+1];
          list_len--;
        end
      end
      KIND_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.data_out = list_values[p];
      end
      // unused operation code is rejected
      default: res.status = ST_RANGE;
    endcase
    res.count = list_len[COUNT_W-1:0];
    pending_results.push_back(res);
  endtask

  // predict on accepted items, compare accepted results
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      if (req_valid && !req_stall) apply_list_op(kind, position, data_in);
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: data_out %0d status %0d count %0d",
                 data_out, status, count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, data_out);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= pending_results.size();
  end

endmodule

// ===== tb/sv/indexed_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_tb: stimulus and verdict for the indexed list store
// Drives directed corner items, a fill to capacity and a drain, then mixed
// random operations, with random gaps and stalls on both channels and at
// least one long result hold-off. The checker beside the block scores it.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
  import ilst_pkg::*;

  localparam int CAPACITY   = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam int MIXED_OPS  = 490;

  // operation code the block has no use for
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [KIND_W-1:0]          kind      = '0;
  logic [POS_W-1:0]           position  = '0;
  logic signed [DATA_W-1:0]   data_in   = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic signed [DATA_W-1:0]   data_out;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         count;
  int                         fail_count;
  int                         pending;

  // list length as seen by the stimulus, used to aim positions
  int list_len    = 0;
  int steady_left = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  indexed_list_store #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (DATA_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .position  (position),
    .data_in   (data_in),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .data_out  (data_out),
    .status    (status),
    .count     (count)
  );

  indexed_list_store_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .position   (position),
    .data_in    (data_in),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .data_out   (data_out),
    .status     (status),
    .count      (count),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // sender gap: runs with no gaps, otherwise mostly short and a few long
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) steady_left = $urandom_range(20, 50);
    if (r < 45) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // position in 0..hi, or anywhere in the field when hi is negative
  function automatic logic [POS_W-1:0] pick_pos(int hi);
    if (hi < 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, (hi > 255) ? 255 : hi));
  endfunction

  // offer one item and wait until it is taken
  task automatic send_op(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    position  <= pos;
    data_in   <= value;
    do @(posedge clk); while (req_stall);
    if (op == KIND_INSERT && int'(pos) <= list_len && list_len < CAPACITY) list_len++;
    else if (op == KIND_REMOVE && int'(pos) < list_len) list_len--;
  endtask

  // result side: quiet runs, noisy runs, occasional long holds
  initial begin : result_sink
    int  hold_left;
    int  run_left;
    int  cyc;
    bit  quiet;
    hold_left = 0;
    run_left  = 0;
    cyc       = 0;
    quiet     = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        quiet    = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      // long hold-off so the waiting result stalls the block's input
      if (hold_left == 0 && (cyc % 1200) == 400) hold_left = $urandom_range(40, 80);
      if (hold_left == 0 && !quiet && $urandom_range(0, 99) == 0)
        hold_left = $urandom_range(8, 25);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (quiet) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int r;
    logic [KIND_W-1:0] op;
    logic [POS_W-1:0]  pos;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty store corners
    send_op(KIND_READ,   8'd0,   32'sd5);
    send_op(KIND_REMOVE, 8'd0,   32'sd6);
    send_op(KIND_INSERT, 8'd1,   32'sd7);
    // build a short list: first, append, prepend, middle
    send_op(KIND_INSERT, 8'd0,   32'h7FFF_FFFF);
    send_op(KIND_INSERT, 8'd1,   32'h8000_0000);
    send_op(KIND_INSERT, 8'd0,   32'hFFFF_FFFF);
    send_op(KIND_INSERT, 8'd1,   32'sd0);
    send_op(KIND_READ,   8'd0,   32'sd0);
    send_op(KIND_READ,   8'd1,   32'sd0);
    send_op(KIND_READ,   8'd2,   32'sd0);
    send_op(KIND_READ,   8'd3,   32'hFFFF_FFFF);
    // reads and insert past the end
    send_op(KIND_READ,   8'd4,   32'sd0);
    send_op(KIND_READ,   8'd255, 32'sd0);
    send_op(KIND_INSERT, 8'd255, 32'h1234_5678);
    // unused operation code
    send_op(KIND_UNUSED, 8'd0,   32'sd0);
    send_op(KIND_UNUSED, 8'd255, 32'hFFFF_FFFF);
    // remove last, first, last again, then one past the end
    send_op(KIND_REMOVE, 8'd3,   32'sd0);
    send_op(KIND_REMOVE, 8'd0,   32'sd0);
    send_op(KIND_REMOVE, 8'd1,   32'sd0);
    send_op(KIND_REMOVE, 8'd1,   32'sd0);

    // fill to capacity at random positions
    while (list_len < CAPACITY) send_op(KIND_INSERT, pick_pos(list_len), $urandom);
    // inserts into a full store
    repeat (6) send_op(KIND_INSERT, pick_pos(list_len), $urandom);
    send_op(KIND_INSERT, 8'd255, $urandom);
    // reads across the full store
    repeat (40) send_op(KIND_READ, pick_pos(list_len - 1), $urandom);
    send_op(KIND_READ, 8'd255, $urandom);
    send_op(KIND_REMOVE, 8'd255, $urandom);
    // drain to empty at random positions
    while (list_len > 0) send_op(KIND_REMOVE, pick_pos(list_len - 1), $urandom);

    // mixed operations, mostly aimed at valid positions
    repeat (MIXED_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op  = KIND_INSERT;
        pos = (r < 36) ? pick_pos(list_len) : pick_pos(-1);
      end else if (r < 65) begin
        op  = KIND_REMOVE;
        pos = (r < 62) ? pick_pos(list_len - 1) : pick_pos(-1);
      end else if (r < 90) begin
        op  = KIND_READ;
        pos = (r < 87) ? pick_pos(list_len - 1) : pick_pos(-1);
      end else if (r < 95) begin
        op  = KIND_UNUSED;
        pos = pick_pos(-1);
      end else begin
        op  = KIND_W'($urandom_range(0, 3));
        pos = pick_pos(-1);
      end
      send_op(op, pos, $urandom);
    end
    req_valid <= 1'b0;

    // let the last item reach the checker, wait out the outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ilst_pkg.sv
src/ilst_cell.sv
src/indexed_list_store.sv
src/ilst_checker.sv
tb/sv/indexed_list_store_checker.sv
tb/sv/indexed_list_store_tb.sv
